[hdl/tsnb_pkg.sv]
package tsnb_pkg;

  // Texture geometry
  localparam int MaxDim   = 256;
  localparam int DimW     = 9;
  localparam int CoordW   = 8;
  localparam int AddrW    = 2 * CoordW;
  localparam int MemDepth = MaxDim * MaxDim;

  // Arithmetic widths
  localparam int FracW  = 16;
  localparam int ScaleW = DimW + FracW;
  localparam int WtW    = 9;
  localparam int WgtW   = 17;
  localparam int ChanW  = 8;
  localparam int NumChan = 4;
  localparam int AccW   = 24;
  localparam int TexelW = NumChan * ChanW;

  // Stream payload widths
  localparam int InDataW  = 112;
  localparam int OutDataW = TexelW;

  // Full weight (1.0 in 1.8 fixed point)
  localparam logic [WtW-1:0] WtOne = WtW'(256);

  // Operation codes carried in tuser
  localparam logic FuncWrite  = 1'b0;
  localparam logic FuncSample = 1'b1;

  // Filter modes
  localparam logic ModeNearest  = 1'b0;
  localparam logic ModeBilinear = 1'b1;

  // Register map (index = paddr[3:2])
  typedef enum logic [1:0] {
    REG_FILTER_MODE = 2'd0,
    REG_TEX_WIDTH   = 2'd1,
    REG_TEX_HEIGHT  = 2'd2
  } reg_idx_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_INDEX,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            filter_mode;
    logic [DimW-1:0] tex_width;
    logic [DimW-1:0] tex_height;
  } cfg_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;   // capture sample coordinates
    logic       write;  // store texel from the input transfer
    logic       scale;  // register scaled coordinates
    logic       index;  // register texel indices and weights, clear sums
    logic       rd;     // issue a texel read
    logic [1:0] sel;    // neighbour: bit 0 right, bit 1 below
    logic       emit;   // load the result register
  } cmd_t;

  // Size register to size in use
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] r);
    logic [DimW-1:0] d;
    if (r == '0) begin
      d = DimW'(1);
    end else if (r > DimW'(MaxDim)) begin
      d = DimW'(MaxDim);
    end else begin
      d = r;
    end
    return d;
  endfunction

endpackage

[hdl/tsnb_ctrl.sv]
module tsnb_ctrl
  import tsnb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid,
  input  logic s_tuser,
  output logic s_tready,
  input  logic filter_mode_i,
  input  logic out_busy_i,
  output cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] sel_q, sel_d;

  // State and neighbour counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid && (s_tuser == FuncSample)) state_d = ST_SCALE;
      end
      ST_SCALE: state_d = ST_INDEX;
      ST_INDEX: begin
        state_d = ST_READ;
        sel_d   = '0;
      end
      ST_READ: begin
        if ((filter_mode_i == ModeNearest) || (sel_q == '1)) begin
          state_d = ST_DRAIN;
        end else begin
          sel_d = sel_q + 2'd1;
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_busy_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o    = '0;
    s_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd_o.load  = s_tvalid && (s_tuser == FuncSample);
        cmd_o.write = s_tvalid && (s_tuser == FuncWrite);
      end
      ST_SCALE: cmd_o.scale = 1'b1;
      ST_INDEX: cmd_o.index = 1'b1;
      ST_READ: begin
        cmd_o.rd  = 1'b1;
        cmd_o.sel = sel_q;
      end
      ST_DRAIN: ;
      ST_DONE:  cmd_o.emit = !out_busy_i;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // An accepted sample starts the scale step on the next cycle
  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid && s_tready && (s_tuser == FuncSample)) |=> (state_q == ST_SCALE))
    else $error("sample accepted but scale step not entered");

  // A result is never loaded over one still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !out_busy_i)
    else $error("result register overwritten");

  // Nearest mode reads exactly one texel
  a_nearest_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_READ) && (filter_mode_i == ModeNearest)) |=> (state_q == ST_DRAIN))
    else $error("nearest sample issued more than one read");

  // Reads always start with the base texel
  a_sel_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INDEX) |=> (sel_q == '0))
    else $error("read sequence does not start at base texel");
`endif

endmodule

[hdl/tsnb_dp.sv]
module tsnb_dp
  import tsnb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  cfg_t                cfg_i,
  input  logic [InDataW-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,
  output logic                out_busy_o
);

  logic [TexelW-1:0] mem [MemDepth];

  logic [FracW-1:0]  u_frac_q, v_frac_q;
  logic [ScaleW-1:0] su_q, sv_q;
  logic [CoordW-1:0] x0_q, x1_q, y0_q, y1_q, tu_q, tv_q;
  logic [CoordW-1:0] x0_d, x1_d, y0_d, y1_d;
  logic [WgtW-1:0]   wgt_q, wgt_d;
  logic              rd_pend_q;
  logic [TexelW-1:0] rdata_q;
  logic [AccW-1:0]   acc_q [NumChan];
  logic [AccW-1:0]   acc_d [NumChan];
  logic [OutDataW-1:0] out_q;
  logic              out_valid_q, out_valid_d;

  logic [DimW-1:0]   w_eff, h_eff;
  logic [AddrW-1:0]  wr_addr, rd_addr;
  logic [WtW-1:0]    wx, wy;

  assign w_eff = eff_dim(cfg_i.tex_width);
  assign h_eff = eff_dim(cfg_i.tex_height);

  // Input fields: coord_u 31:0, coord_v 63:32, texel_x 71:64, texel_y 79:72,
  // texel_data 111:80
  assign wr_addr = {s_tdata[79:72], s_tdata[71:64]};

  // Coordinate capture and scaling to the size in use
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      u_frac_q <= s_tdata[FracW-1:0];
      v_frac_q <= s_tdata[32 +: FracW];
    end
    if (cmd_i.scale) begin
      su_q <= ScaleW'(w_eff) * ScaleW'(u_frac_q);
      sv_q <= ScaleW'(h_eff) * ScaleW'(v_frac_q);
    end
  end

  // Texel indices: clamp to edge, +1 neighbour wraps to zero
  always_comb begin
    logic [DimW-1:0] xi, yi, xm, ym, xn, yn;
    xi = su_q[ScaleW-1:FracW];
    yi = sv_q[ScaleW-1:FracW];
    xm = w_eff - DimW'(1);
    ym = h_eff - DimW'(1);
    if (xi > xm) xi = xm;
    if (yi > ym) yi = ym;
    xn = xi + DimW'(1);
    yn = yi + DimW'(1);
    if (xn >= w_eff) xn = '0;
    if (yn >= h_eff) yn = '0;
    x0_d = xi[CoordW-1:0];
    y0_d = yi[CoordW-1:0];
    x1_d = xn[CoordW-1:0];
    y1_d = yn[CoordW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.index) begin
      x0_q <= x0_d;
      x1_q <= x1_d;
      y0_q <= y0_d;
      y1_q <= y1_d;
      tu_q <= su_q[FracW-1:FracW-CoordW];
      tv_q <= sv_q[FracW-1:FracW-CoordW];
    end
  end

  // Read address and blend weight of the selected neighbour
  assign rd_addr = {(cmd_i.sel[1] ? y1_q : y0_q), (cmd_i.sel[0] ? x1_q : x0_q)};

  always_comb begin
    if (cfg_i.filter_mode == ModeNearest) begin
      wx = WtOne;
      wy = WtOne;
    end else begin
      wx = cmd_i.sel[0] ? WtW'(tu_q) : (WtOne - WtW'(tu_q));
      wy = cmd_i.sel[1] ? WtW'(tv_q) : (WtOne - WtW'(tv_q));
    end
    wgt_d = WgtW'(wx) * WgtW'(wy);
  end

  // Texture store, single port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem[wr_addr] <= s_tdata[80 +: TexelW];
    end else if (cmd_i.rd) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) wgt_q <= wgt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd;
    end
  end

  // Weighted per-channel sums, one texel per cycle
  always_comb begin
    for (int k = 0; k < NumChan; k++) begin
      acc_d[k] = acc_q[k];
      if (cmd_i.index) begin
        acc_d[k] = '0;
      end else if (rd_pend_q) begin
        acc_d[k] = acc_q[k] + AccW'(rdata_q[k*ChanW +: ChanW]) * AccW'(wgt_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumChan; k++) acc_q[k] <= acc_d[k];
  end

  // Result register
  assign out_valid_d = cmd_i.emit ? 1'b1 : (out_valid_q && !m_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      for (int k = 0; k < NumChan; k++) begin
        out_q[k*ChanW +: ChanW] <= acc_q[k][AccW-1 -: ChanW];
      end
    end
  end

  assign m_tvalid   = out_valid_q;
  assign m_tdata    = out_q;
  assign out_busy_o = out_valid_q && !m_tready;

endmodule

[hdl/texture_sampler_nearest_bilinear_core.sv]
// Texture sampler with a 256 x 256 RGBA8888 texel store.
// Input stream: s_tuser selects the operation (0 write texel, 1 sample).
//   A write stores s_tdata texel_data at (texel_x, texel_y) and gives no
//   result. A sample wraps coord_u/coord_v (Q16.16) to their fraction,
//   scales by the size in use and returns one RGBA result.
// Output stream: red, green, blue, alpha, red in the low byte.
// Flow: a sample steps through scale, index, texel reads, drain and done;
//   a bilinear sample reads four texels and a nearest one reads one, on the
//   single memory port. A new item is taken only in the idle state, so not
//   before the previous sample has reached the output register.
// APB port: filter_mode at 0x0, tex_width at 0x4, tex_height at 0x8; write
//   only while the block is idle. pready is always high.
// Reset: registers return to bilinear, 256 x 256; the texel store is not
//   cleared, so texels must be written before they are sampled.
// Stall: a result waits in the output register while m_tready is low; the
//   next item is still accepted and worked on up to its own result.
module texture_sampler_nearest_bilinear_core
  import tsnb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // coord_u 31:0, coord_v 63:32, texel_x 71:64, texel_y 79:72, texel_data 111:80
  input  logic [InDataW-1:0]   s_tdata,
  // func
  input  logic                 s_tuser,
  // Output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // red 7:0, green 15:8, blue 23:16, alpha 31:24
  output logic [OutDataW-1:0]  m_tdata,
  // Configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t     cfg_q, cfg_d;
  cmd_t     cmd;
  logic     out_busy;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FILTER_MODE: cfg_d.filter_mode = pwdata[0];
        REG_TEX_WIDTH:   cfg_d.tex_width   = pwdata[DimW-1:0];
        REG_TEX_HEIGHT:  cfg_d.tex_height  = pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_mode <= ModeBilinear;
      cfg_q.tex_width   <= DimW'(MaxDim);
      cfg_q.tex_height  <= DimW'(MaxDim);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_FILTER_MODE: prdata = 32'(cfg_q.filter_mode);
      REG_TEX_WIDTH:   prdata = 32'(cfg_q.tex_width);
      REG_TEX_HEIGHT:  prdata = 32'(cfg_q.tex_height);
      default:         prdata = '0;
    endcase
  end

  tsnb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid      (s_tvalid),
    .s_tuser       (s_tuser),
    .s_tready      (s_tready),
    .filter_mode_i (cfg_q.filter_mode),
    .out_busy_i    (out_busy),
    .cmd_o         (cmd)
  );

  tsnb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg_q),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .out_busy_o (out_busy)
  );

endmodule

[tb/sv/tb_texture_sampler_nearest_bilinear_core.sv]
module tb_texture_sampler_nearest_bilinear_core;
  import tsnb_pkg::*;

  localparam int StuckLimit   = 5000;  // cycles with no transfer while work is pending
  localparam int HoldCycles   = 400;   // long receiver hold-off
  localparam int SettleCycles = 16;    // covers the longest sample latency
  localparam int PhaseItems   = 150;
  localparam int RandPhases   = 10;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_SAMPLE,
    ROW_CFG
  } row_kind_e;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_e;

  // One input transfer
  typedef struct packed {
    logic        func;
    logic [31:0] u;
    logic [31:0] v;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [31:0] data;
  } stim_t;

  // Directed row: chk marks a typed-in result in rgba
  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] u;
    logic [31:0] v;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [31:0] data;
    logic        chk;
    logic [31:0] rgba;
    reg_idx_e    cfg_reg;
    logic [8:0]  val;
  } row_t;

  typedef struct packed {
    logic       mode;
    logic [8:0] w;
    logic [8:0] h;
  } phase_cfg_t;

  localparam row_t DirRows [25] = '{
    '{ROW_WRITE,  32'hFFFF_FFFF, 32'h0000_0000, 8'd0,   8'd0,   32'hA1B2_C3D4, 1'b0, 32'h0,
      REG_FILTER_MODE, 9'd0},
    '{ROW_WRITE,  32'h0000_0000, 32'hFFFF_FFFF, 8'd1,   8'd0,   32'h0000_0000, 1'b0, 32'h0,
      REG_FILTER_MODE, 9'd0},
    '{ROW_WRITE,  32'h5555_5555, 32'hAAAA_AAAA, 8'd0,   8'd1,   32'hFFFF_FFFF, 1'b0, 32'h0,
      REG_FILTER_MODE, 9'd0},
    '{ROW_WRITE,  32'hAAAA_AAAA, 32'h5555_5555, 8'd1,   8'd1,   32'h1234_5678, 1'b0, 32'h0,
      REG_FILTER_MODE, 9'd0},
    '{ROW_WRITE,  32'h7FFF_FFFF, 32'h8000_0000, 8'd255, 8'd255, 32'hFFFF_FFFF, 1'b0, 32'h0,
      REG_FILTER_MODE, 9'd0},
    '{ROW_WRITE,  32'h8000_0000, 32'h7FFF_FFFF, 8'd255, 8'd0,   32'h8080_8080, 1'b0, 32'h0,
      REG_FILTER_MODE, 9'd0},
    '{ROW_WRITE,  32'h0000_0000, 32'h0000_0000, 8'd0,   8'd255, 32'h0102_0304, 1'b0, 32'h0,
      REG_FILTER_MODE, 9'd0},
    // reset state is bilinear 256 x 256; zero weights give the corner texel
    '{ROW_SAMPLE, 32'h0000_0000, 32'h0000_0000, 8'hFF,  8'hFF,  32'hFFFF_FFFF, 1'b1,
      32'hA1B2_C3D4, REG_FILTER_MODE, 9'd0},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 8'h00,  8'h00,  32'h0000_0000, 1'b0, 32'h0,
      REG_FILTER_MODE, 9'd0},
    '{ROW_SAMPLE, 32'h0000_8000, 32'h0000_8000, 8'h5A,  8'hA5,  32'h5A5A_A5A5, 1'b0, 32'h0,
      REG_FILTER_MODE, 9'd0},
    // negative coordinates wrap, right and lower neighbours wrap to zero
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00,  8'h00,  32'h0000_0000, 1'b0, 32'h0,
      REG_FILTER_MODE, 9'd0},
    '{ROW_SAMPLE, 32'h0003_0000, 32'hFFFD_0000, 8'h00,  8'h00,  32'h0000_0000, 1'b1,
      32'hA1B2_C3D4, REG_FILTER_MODE, 9'd0},
    '{ROW_CFG,    32'h0,         32'h0,         8'd0,   8'd0,   32'h0,         1'b0, 32'h0,
      REG_FILTER_MODE, {8'd0, ModeNearest}},
    '{ROW_SAMPLE, 32'h0000_0000, 32'h0000_0000, 8'h00,  8'h00,  32'h0000_0000, 1'b1,
      32'hA1B2_C3D4, REG_FILTER_MODE, 9'd0},
    '{ROW_SAMPLE, 32'h0000_FFFF, 32'h8000_FFFF, 8'h00,  8'h00,  32'h0000_0000, 1'b1,
      32'hFFFF_FFFF, REG_FILTER_MODE, 9'd0},
    // zero width is taken as one, oversize height as the full store
    '{ROW_CFG,    32'h0,         32'h0,         8'd0,   8'd0,   32'h0,         1'b0, 32'h0,
      REG_TEX_WIDTH, 9'd0},
    '{ROW_CFG,    32'h0,         32'h0,         8'd0,   8'd0,   32'h0,         1'b0, 32'h0,
      REG_TEX_HEIGHT, 9'd511},
    '{ROW_SAMPLE, 32'h1234_ABCD, 32'h0000_0000, 8'h00,  8'h00,  32'h0000_0000, 1'b1,
      32'hA1B2_C3D4, REG_FILTER_MODE, 9'd0},
    '{ROW_SAMPLE, 32'hFEDC_8001, 32'h0000_FFFF, 8'h00,  8'h00,  32'h0000_0000, 1'b1,
      32'h0102_0304, REG_FILTER_MODE, 9'd0},
    '{ROW_CFG,    32'h0,         32'h0,         8'd0,   8'd0,   32'h0,         1'b0, 32'h0,
      REG_TEX_HEIGHT, 9'd1},
    '{ROW_CFG,    32'h0,         32'h0,         8'd0,   8'd0,   32'h0,         1'b0, 32'h0,
      REG_FILTER_MODE, {8'd0, ModeBilinear}},
    // 1 x 1 bilinear: all four taps are the same texel
    '{ROW_SAMPLE, 32'h0000_8000, 32'h0001_8000, 8'h00,  8'h00,  32'h0000_0000, 1'b1,
      32'hA1B2_C3D4, REG_FILTER_MODE, 9'd0},
    '{ROW_CFG,    32'h0,         32'h0,         8'd0,   8'd0,   32'h0,         1'b0, 32'h0,
      REG_TEX_WIDTH, 9'd256},
    '{ROW_CFG,    32'h0,         32'h0,         8'd0,   8'd0,   32'h0,         1'b0, 32'h0,
      REG_TEX_HEIGHT, 9'd256},
    '{ROW_SAMPLE, 32'h0001_4000, 32'h0000_C000, 8'h00,  8'h00,  32'h0000_0000, 1'b0, 32'h0,
      REG_FILTER_MODE, 9'd0}
  };

  // Fixed settings for the first random phases, extremes first
  localparam phase_cfg_t PhaseCfg [6] = '{
    '{ModeNearest,  9'd1,   9'd1},
    '{ModeBilinear, 9'd256, 9'd256},
    '{ModeBilinear, 9'd0,   9'd511},
    '{ModeBilinear, 9'd256, 9'd1},
    '{ModeNearest,  9'd1,   9'd256},
    '{ModeBilinear, 9'd2,   9'd2}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;   // coord_u, coord_v, texel_x, texel_y, texel_data
  logic                s_tuser;   // func
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;   // red, green, blue, alpha
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Shadow of the texel store and the registers
  logic [31:0] texel_mem   [MemDepth];
  bit          texel_known [MemDepth];
  logic        cur_mode  = ModeBilinear;
  logic [8:0]  cur_w_reg = 9'd256;
  logic [8:0]  cur_h_reg = 9'd256;

  logic [31:0] rgba_due [$];
  int          mismatches = 0;
  int          item_count = 0;
  int          burst_left = 0;
  int          stuck      = 0;
  bit          hold_req   = 1'b0;
  logic [31:0] want;
  string       chan_name [4] = '{"red", "green", "blue", "alpha"};

  // Receiver state
  rx_mode_e    rx_mode   = RX_OPEN;
  int          rx_left   = 0;
  int          hold_left = 0;
  logic [7:0]  rx_pat    = 8'b1101_0110;

  texture_sampler_nearest_bilinear_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Size register to size in use
  function automatic int unsigned usable_size(input logic [8:0] r);
    if (r == 9'd0) return 1;
    if (r > 9'(MaxDim)) return MaxDim;
    return 32'(r);
  endfunction

  // Base texel, +1 neighbours and 8-bit weights for a coordinate pair
  function automatic void locate(input logic [31:0] u, input logic [31:0] v,
                                 output logic [7:0] x0, output logic [7:0] x1,
                                 output logic [7:0] y0, output logic [7:0] y1,
                                 output logic [7:0] tu, output logic [7:0] tv);
    int unsigned w;
    int unsigned h;
    logic [31:0] su;
    logic [31:0] sv;
    w  = usable_size(cur_w_reg);
    h  = usable_size(cur_h_reg);
    su = w * u[15:0];
    sv = h * v[15:0];
    x0 = (su[31:16] > w - 1) ? 8'(w - 1) : su[23:16];
    y0 = (sv[31:16] > h - 1) ? 8'(h - 1) : sv[23:16];
    x1 = (x0 + 1 >= w) ? 8'd0 : x0 + 8'd1;
    y1 = (y0 + 1 >= h) ? 8'd0 : y0 + 8'd1;
    tu = su[15:8];
    tv = sv[15:8];
  endfunction

  // Expected RGBA for a sample under the current settings
  function automatic logic [31:0] sample_texture(input logic [31:0] u, input logic [31:0] v);
    logic [7:0]  x0, x1, y0, y1, tu, tv;
    logic [31:0] t00, t01, t10, t11;
    logic [31:0] rgba;
    logic [31:0] acc;
    int unsigned h0, h1;
    locate(u, v, x0, x1, y0, y1, tu, tv);
    t00 = texel_mem[{y0, x0}];
    if (cur_mode == ModeNearest) return t00;
    t01 = texel_mem[{y0, x1}];
    t10 = texel_mem[{y1, x0}];
    t11 = texel_mem[{y1, x1}];
    for (int k = 0; k < NumChan; k++) begin
      h0  = t00[8*k +: 8] * (32'd256 - tu) + t01[8*k +: 8] * tu;
      h1  = t10[8*k +: 8] * (32'd256 - tu) + t11[8*k +: 8] * tu;
      acc = h0 * (32'd256 - tv) + h1 * tv;
      rgba[8*k +: 8] = acc[23:16];
    end
    return rgba;
  endfunction

  // Mostly small sizes, now and then zero, full or oversize
  function automatic logic [8:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(1, 12));
    endcase
  endfunction

  // Random Q16.16 coordinate, fraction sometimes at its extremes
  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 7))
      0:       c[15:0] = 16'h0000;
      1:       c[15:0] = 16'hFFFF;
      default: ;
    endcase
    return c;
  endfunction

  // Offer one item in bursts with random gaps; update the shadow on transfer
  task automatic send_item(input stim_t it, input bit chk, input logic [31:0] typed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tuser  <= it.func;
    s_tdata  <= {it.data, it.y, it.x, it.v, it.u};
    do @(posedge clk_i); while (!s_tready);
    item_count++;
    if (it.func == FuncWrite) begin
      texel_mem[{it.y, it.x}]   = it.data;
      texel_known[{it.y, it.x}] = 1'b1;
    end else begin
      rgba_due.push_back(chk ? typed : sample_texture(it.u, it.v));
    end
  endtask

  // Write any texel the sample would read that has never been written, then sample
  task automatic sample_at(input stim_t it, input bit chk, input logic [31:0] typed);
    logic [7:0] x0, x1, y0, y1, tu, tv;
    logic [7:0] xs [4];
    logic [7:0] ys [4];
    int         taps;
    stim_t      fill;
    locate(it.u, it.v, x0, x1, y0, y1, tu, tv);
    xs   = '{x0, x1, x0, x1};
    ys   = '{y0, y0, y1, y1};
    taps = (cur_mode == ModeBilinear) ? 4 : 1;
    for (int k = 0; k < taps; k++) begin
      if (!texel_known[{ys[k], xs[k]}]) begin
        fill.func = FuncWrite;
        fill.u    = $urandom;
        fill.v    = $urandom;
        fill.x    = xs[k];
        fill.y    = ys[k];
        fill.data = $urandom;
        send_item(fill, 1'b0, 32'h0);
      end
    end
    it.func = FuncSample;
    send_item(it, chk, typed);
  endtask

  // Stop offering, wait for every result, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (rgba_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    burst_left = 0;
  endtask

  // APB register write, only with the block idle
  task automatic cfg_write(input reg_idx_e idx, input logic [8:0] val);
    drain_results();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {23'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_FILTER_MODE: cur_mode  = val[0];
      REG_TEX_WIDTH:   cur_w_reg = val;
      default:         cur_h_reg = val;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (rgba_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
      end else begin
        want = rgba_due.pop_front();
        for (int k = 0; k < NumChan; k++) begin
          if (m_tdata[8*k +: 8] !== want[8*k +: 8]) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, chan_name[k],
                     want[8*k +: 8], m_tdata[8*k +: 8]);
          end
        end
      end
    end
  end

  // Watchdog: no transfer for too long while work is pending
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (!s_tvalid && rgba_due.size() == 0)) begin
      stuck <= 0;
    end else if (stuck >= StuckLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // Receiver: stall windows of varying character, plus one long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          rx_left = $urandom_range(8, 80);
        end
        rx_left--;
        rx_pat = {rx_pat[6:0], rx_pat[7]};
        case (rx_mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 5) == 0);
          default:   m_tready <= rx_pat[0];
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    row_t       r;
    stim_t      it;
    phase_cfg_t pc;
    int         start;
    bit         held;
    bit         paused;
    s_tvalid = 1'b0;
    s_tuser  = FuncWrite;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst_ni   = 1'b0;
    held     = 1'b0;
    paused   = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    for (int i = 0; i < $size(DirRows); i++) begin
      r       = DirRows[i];
      it.func = (r.kind == ROW_WRITE) ? FuncWrite : FuncSample;
      it.u    = r.u;
      it.v    = r.v;
      it.x    = r.x;
      it.y    = r.y;
      it.data = r.data;
      case (r.kind)
        ROW_CFG:   cfg_write(r.cfg_reg, r.val);
        ROW_WRITE: send_item(it, 1'b0, 32'h0);
        default:   sample_at(it, r.chk, r.rgba);
      endcase
    end

    // Random phases, each under its own settings
    for (int p = 0; p < RandPhases; p++) begin
      if (p < $size(PhaseCfg)) begin
        pc = PhaseCfg[p];
      end else begin
        pc.mode = 1'($urandom_range(0, 1));
        pc.w    = pick_size();
        pc.h    = pick_size();
      end
      cfg_write(REG_FILTER_MODE, {8'd0, pc.mode});
      cfg_write(REG_TEX_WIDTH, pc.w);
      cfg_write(REG_TEX_HEIGHT, pc.h);
      start = item_count;
      while (item_count - start < PhaseItems) begin
        // long receiver hold-off while items keep coming
        if (p == 0 && !held && item_count - start >= 40) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        // sender pause until the pipeline is empty
        if (p == 2 && !paused && item_count - start >= 60) begin
          drain_results();
          paused = 1'b1;
        end
        it.u    = rand_coord();
        it.v    = rand_coord();
        it.x    = 8'($urandom);
        it.y    = 8'($urandom);
        it.data = $urandom;
        if ($urandom_range(0, 3) == 0) begin
          it.func = FuncWrite;
          if ($urandom_range(0, 3) != 0) begin
            it.x = 8'($urandom_range(0, usable_size(cur_w_reg) - 1));
            it.y = 8'($urandom_range(0, usable_size(cur_h_reg) - 1));
          end
          send_item(it, 1'b0, 32'h0);
        end else begin
          sample_at(it, 1'b0, 32'h0);
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
hdl/tsnb_pkg.sv
hdl/tsnb_ctrl.sv
hdl/tsnb_dp.sv
hdl/texture_sampler_nearest_bilinear_core.sv
tb/sv/tb_texture_sampler_nearest_bilinear_core.sv
